// ----- rtl/core/ect_pkg.sv -----
// ----------------------------------------------------------------------------
// ect_pkg
// Shared widths, reciprocal constants, month table and stage structs for the
// epoch seconds to civil time converter.
// ----------------------------------------------------------------------------
package ect_pkg;

  // Field widths
  localparam int SEC_W  = 32;   // epoch seconds
  localparam int OFS_W  = 18;   // UTC offset register
  localparam int SUM_W  = 34;   // signed sum of seconds, offset and bias
  localparam int T_W    = 33;   // biased seconds, always positive
  localparam int DAY_W  = 16;   // days since 1901-01-01
  localparam int SOD_W  = 17;   // second of day
  localparam int YEAR_W = 11;
  localparam int DOY_W  = 9;

  // Configuration register indexes
  localparam logic [1:0] REG_UTC_OFFSET = 2'd0;
  localparam logic [1:0] REG_DST_ACTIVE = 2'd1;

  // Seconds from 1901-01-01 to 1970-01-01 (25202 days). Day zero is a Tuesday
  // and starts a four-year cycle; every fourth year is leap up to 2099.
  localparam logic [SUM_W-1:0] EPOCH_BIAS = 34'd2177452800;
  localparam logic [YEAR_W-1:0] BASE_YEAR  = 11'd1901;
  localparam logic [2:0]        BASE_WDAY  = 3'd2;

  // 86400 = 128 * 675; floor reciprocals, quotient low by at most one
  localparam logic [26:0] RCP_675  = 27'd101806632;  // 2^36 / 675
  localparam logic [15:0] RCP_1461 = 16'd45933;      // 2^26 / 1461
  localparam logic [13:0] RCP_7    = 14'd9362;       // 2^16 / 7
  localparam logic [16:0] RCP_3600 = 17'd74565;      // 2^28 / 3600
  localparam logic [12:0] RCP_60   = 13'd4369;       // 2^18 / 60

  localparam logic [10:0] DAY_HI_DIV = 11'd675;
  localparam logic [11:0] CYC_DAYS   = 12'd1461;
  localparam logic [8:0]  YEAR_DAYS  = 9'd365;
  localparam logic [12:0] SEC_HOUR   = 13'd3600;
  localparam logic [6:0]  SEC_MIN    = 7'd60;
  localparam logic [3:0]  WEEK_DAYS  = 4'd7;

  // Cumulative days before each month
  localparam logic [8:0] CUM_NORM [13] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
  localparam logic [8:0] CUM_LEAP [13] = '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] mon);
    cum_days = leap ? CUM_LEAP[mon] : CUM_NORM[mon];
  endfunction

  // Day split front end to calendar back end
  typedef struct packed {
    logic             vld;
    logic             dst;
    logic [DAY_W-1:0] days;
    logic [SOD_W-1:0] sod;
  } ect_days_t;

  // Finished result
  typedef struct packed {
    logic              vld;
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        mday;
    logic [DOY_W-1:0]  yday;
    logic [2:0]        wday;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic              dst;
  } ect_result_t;

endpackage

// ----- rtl/core/ect_day_split.sv -----
// ----------------------------------------------------------------------------
// ect_day_split
// Three-stage front end: applies offset and bias, then splits the biased
// seconds into whole days and second of day by reciprocal multiplication.
// ----------------------------------------------------------------------------
module ect_day_split
  import ect_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_vld,
  input  logic [SEC_W-1:0] req_secs,
  input  logic             req_local,
  input  logic [OFS_W-1:0] utc_ofs,
  input  logic             dst_on,
  output ect_days_t        days_out
);

  // Stage 1: biased seconds
  logic             s1_vld_r;
  logic             s1_dst_r;
  logic [T_W-1:0]   s1_t_r;
  logic [SUM_W-1:0] sum_nxt;

  always_comb begin
    sum_nxt = {{(SUM_W-SEC_W){req_secs[SEC_W-1]}}, req_secs} + EPOCH_BIAS;
    if (req_local) begin
      sum_nxt = sum_nxt + {{(SUM_W-OFS_W){utc_ofs[OFS_W-1]}}, utc_ofs};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= req_vld;
    end
    s1_t_r   <= sum_nxt[T_W-1:0];
    s1_dst_r <= req_local & dst_on;
  end

  // Stage 2: estimate days = (t >> 7) / 675
  logic             s2_vld_r;
  logic             s2_dst_r;
  logic [DAY_W-1:0] s2_q_r;
  logic [10:0]      s2_nlo_r;
  logic [6:0]       s2_lo7_r;
  logic [52:0]      day_prod;

  assign day_prod = 53'(s1_t_r[T_W-1:7]) * 53'(RCP_675);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_q_r   <= day_prod[51:36];
    s2_nlo_r <= s1_t_r[17:7];
    s2_lo7_r <= s1_t_r[6:0];
    s2_dst_r <= s1_dst_r;
  end

  // Stage 3: remainder and one-step correction
  logic [25:0]      q_mul;
  logic [10:0]      rem_raw;
  logic [10:0]      rem_fix;
  logic [DAY_W-1:0] days_fix;

  always_comb begin
    q_mul    = 26'(s2_q_r) * 26'(DAY_HI_DIV);
    rem_raw  = s2_nlo_r - q_mul[10:0];
    rem_fix  = rem_raw;
    days_fix = s2_q_r;
    if (rem_raw >= DAY_HI_DIV) begin
      rem_fix  = rem_raw - DAY_HI_DIV;
      days_fix = s2_q_r + 16'd1;
    end
  end

  ect_days_t s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.vld <= 1'b0;
    end else begin
      s3_r.vld <= s2_vld_r;
    end
    s3_r.dst  <= s2_dst_r;
    s3_r.days <= days_fix;
    s3_r.sod  <= {rem_fix[9:0], s2_lo7_r};
  end

  assign days_out = s3_r;

`ifndef NO_ASSERTIONS
  a_sod_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_r.vld |-> s3_r.sod < 17'd86400)
    else $error("second of day out of range");

  a_day_est: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> rem_raw < 11'd1350)
    else $error("day quotient estimate off by more than one");
`endif

endmodule

// ----- rtl/core/ect_civil.sv -----
// ----------------------------------------------------------------------------
// ect_civil
// Four-stage back end: year, day of year, month, day of month and weekday
// from the day count; hour, minute and second from the second of day.
// ----------------------------------------------------------------------------
module ect_civil
  import ect_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ect_days_t   days_in,
  output ect_result_t res_out
);

  // Stage 4: quotient estimates
  logic             s4_vld_r;
  logic             s4_dst_r;
  logic [DAY_W-1:0] s4_days_r;
  logic [SOD_W-1:0] s4_sod_r;
  logic [5:0]       s4_yq_r;
  logic [12:0]      s4_wq_r;
  logic [4:0]       s4_hq_r;
  logic [31:0]      cyc_prod;
  logic [29:0]      wk_prod;
  logic [33:0]      hr_prod;

  assign cyc_prod = 32'(days_in.days) * 32'(RCP_1461);
  assign wk_prod  = 30'(days_in.days) * 30'(RCP_7);
  assign hr_prod  = 34'(days_in.sod) * 34'(RCP_3600);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= days_in.vld;
    end
    s4_dst_r  <= days_in.dst;
    s4_days_r <= days_in.days;
    s4_sod_r  <= days_in.sod;
    s4_yq_r   <= cyc_prod[31:26];
    s4_wq_r   <= wk_prod[28:16];
    s4_hq_r   <= hr_prod[32:28];
  end

  // Stage 5: remainders and corrections
  logic [16:0] cyc_mul;
  logic [11:0] dc_raw;
  logic [10:0] dc_fix;
  logic [5:0]  cyc_fix;
  logic [16:0] wk_mul;
  logic [3:0]  wr_raw;
  logic [3:0]  wr_fix;
  logic [3:0]  wd_sum;
  logic [2:0]  wd_fix;
  logic [17:0] hr_mul;
  logic [12:0] hr_raw;
  logic [11:0] hr_rem;
  logic [4:0]  hr_fix;

  always_comb begin
    cyc_mul = 17'(s4_yq_r) * 17'(CYC_DAYS);
    dc_raw  = s4_days_r[11:0] - cyc_mul[11:0];
    dc_fix  = dc_raw[10:0];
    cyc_fix = s4_yq_r;
    if (dc_raw >= CYC_DAYS) begin
      dc_fix  = 11'(dc_raw - CYC_DAYS);
      cyc_fix = s4_yq_r + 6'd1;
    end

    wk_mul = 17'(s4_wq_r) * 17'(WEEK_DAYS);
    wr_raw = s4_days_r[3:0] - wk_mul[3:0];
    wr_fix = (wr_raw >= WEEK_DAYS) ? wr_raw - WEEK_DAYS : wr_raw;
    wd_sum = wr_fix + 4'(BASE_WDAY);
    wd_fix = (wd_sum >= WEEK_DAYS) ? 3'(wd_sum - WEEK_DAYS) : wd_sum[2:0];

    hr_mul = 18'(s4_hq_r) * 18'(SEC_HOUR);
    hr_raw = s4_sod_r[12:0] - hr_mul[12:0];
    hr_rem = hr_raw[11:0];
    hr_fix = s4_hq_r;
    if (hr_raw >= SEC_HOUR) begin
      hr_rem = 12'(hr_raw - SEC_HOUR);
      hr_fix = s4_hq_r + 5'd1;
    end
  end

  logic        s5_vld_r;
  logic        s5_dst_r;
  logic [5:0]  s5_cyc_r;
  logic [10:0] s5_dc_r;
  logic [2:0]  s5_wd_r;
  logic [4:0]  s5_hour_r;
  logic [11:0] s5_hrem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    s5_dst_r  <= s4_dst_r;
    s5_cyc_r  <= cyc_fix;
    s5_dc_r   <= dc_fix;
    s5_wd_r   <= wd_fix;
    s5_hour_r <= hr_fix;
    s5_hrem_r <= hr_rem;
  end

  // Stage 6: year within cycle, minute estimate
  logic [1:0]        yic;
  logic [10:0]       yic_days;
  logic [24:0]       min_prod;
  logic [YEAR_W-1:0] year_nxt;

  always_comb begin
    if (s5_dc_r >= 11'd1095) begin
      yic = 2'd3;
    end else if (s5_dc_r >= 11'd730) begin
      yic = 2'd2;
    end else if (s5_dc_r >= 11'd365) begin
      yic = 2'd1;
    end else begin
      yic = 2'd0;
    end
    yic_days = 11'(yic) * 11'(YEAR_DAYS);
    year_nxt = BASE_YEAR + {3'd0, s5_cyc_r, 2'b00} + 11'(yic);
    min_prod = 25'(s5_hrem_r) * 25'(RCP_60);
  end

  logic              s6_vld_r;
  logic              s6_dst_r;
  logic [YEAR_W-1:0] s6_year_r;
  logic [DOY_W-1:0]  s6_doy_r;
  logic              s6_leap_r;
  logic [2:0]        s6_wd_r;
  logic [4:0]        s6_hour_r;
  logic [11:0]       s6_hrem_r;
  logic [5:0]        s6_mq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
    s6_dst_r  <= s5_dst_r;
    s6_year_r <= year_nxt;
    s6_doy_r  <= 9'(s5_dc_r - yic_days);
    s6_leap_r <= (yic == 2'd3);
    s6_wd_r   <= s5_wd_r;
    s6_hour_r <= s5_hour_r;
    s6_hrem_r <= s5_hrem_r;
    s6_mq_r   <= min_prod[23:18];
  end

  // Stage 7: month search, minute and second
  logic [3:0]  mon;
  logic [8:0]  mday_raw;
  logic [12:0] min_mul;
  logic [6:0]  sec_raw;
  logic [5:0]  sec_fix;
  logic [5:0]  min_fix;

  always_comb begin
    mon = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (s6_doy_r >= cum_days(s6_leap_r, 4'(k))) begin
        mon = mon + 4'd1;
      end
    end
    mday_raw = s6_doy_r - cum_days(s6_leap_r, mon) + 9'd1;

    min_mul = 13'(s6_mq_r) * 13'(SEC_MIN);
    sec_raw = s6_hrem_r[6:0] - min_mul[6:0];
    sec_fix = sec_raw[5:0];
    min_fix = s6_mq_r;
    if (sec_raw >= SEC_MIN) begin
      sec_fix = 6'(sec_raw - SEC_MIN);
      min_fix = s6_mq_r + 6'd1;
    end
  end

  ect_result_t s7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_r.vld <= 1'b0;
    end else begin
      s7_r.vld <= s6_vld_r;
    end
    s7_r.year   <= s6_year_r;
    s7_r.month  <= mon;
    s7_r.mday   <= mday_raw[4:0];
    s7_r.yday   <= s6_doy_r;
    s7_r.wday   <= s6_wd_r;
    s7_r.hour   <= s6_hour_r;
    s7_r.minute <= min_fix;
    s7_r.second <= sec_fix;
    s7_r.dst    <= s6_dst_r;
  end

  assign res_out = s7_r;

`ifndef NO_ASSERTIONS
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    s7_r.vld |-> (s7_r.month <= 4'd11) && (s7_r.mday != 5'd0) && (s7_r.wday <= 3'd6))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    s7_r.vld |-> (s7_r.hour <= 5'd23) && (s7_r.minute <= 6'd59) && (s7_r.second <= 6'd59))
    else $error("time field out of range");
`endif

endmodule

// ----- rtl/core/epoch_seconds_to_civil_time.sv -----
// Throughput: one request per cycle while busy is low; the seven-stage pipeline never stalls.
// busy is high during reset, is cleared by the first clock edge out of reset, then stays low.
// Reset (synchronous, active low) clears all valid bits and the registers to
// zero offset and daylight off; config writes are taken every cycle out of reset.
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_time
// Converts signed epoch seconds to Gregorian date and time of day, in UTC or
// with the configured local offset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_civil_time
  import ect_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // request
  input  logic              start,
  output logic              busy,
  input  logic [SEC_W-1:0]  in_epoch_seconds,
  input  logic              in_local_mode,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [OFS_W-1:0]  cfg_data,
  // result
  output logic              out_valid,
  output logic [YEAR_W-1:0] out_full_year,
  output logic [3:0]        out_month_index,
  output logic [4:0]        out_day_of_month,
  output logic [DOY_W-1:0]  out_day_of_year,
  output logic [2:0]        out_weekday,
  output logic [4:0]        out_hour_of_day,
  output logic [5:0]        out_minute_of_hour,
  output logic [5:0]        out_second_of_minute,
  output logic              out_daylight_flag
);

  // Configuration registers
  logic [OFS_W-1:0] ofs_r;
  logic             dst_r;
  logic             busy_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r  <= '0;
      dst_r  <= 1'b0;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_UTC_OFFSET: ofs_r <= cfg_data;
          REG_DST_ACTIVE: dst_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  // Pipeline
  ect_days_t   days_w;
  ect_result_t res_w;

  ect_day_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_vld  (start && !busy_r),
    .req_secs (in_epoch_seconds),
    .req_local(in_local_mode),
    .utc_ofs  (ofs_r),
    .dst_on   (dst_r),
    .days_out (days_w)
  );

  ect_civil u_civil (
    .clk    (clk),
    .rst_n  (rst_n),
    .days_in(days_w),
    .res_out(res_w)
  );

  assign out_valid            = res_w.vld;
  assign out_full_year        = res_w.year;
  assign out_month_index      = res_w.month;
  assign out_day_of_month     = res_w.mday;
  assign out_day_of_year      = res_w.yday;
  assign out_weekday          = res_w.wday;
  assign out_hour_of_day      = res_w.hour;
  assign out_minute_of_hour   = res_w.minute;
  assign out_second_of_minute = res_w.second;
  assign out_daylight_flag    = res_w.dst;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for epoch_seconds_to_civil_time. A directed table
// covers the range ends, leap days, offset extremes and the spare register
// indexes. Random phases follow, each with a new offset and daylight
// setting. Results are checked against typed row values or a behavioral predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ect_pkg::*;

  localparam int DAY_SECONDS  = 86400;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 110;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  // Indexes with no register behind them
  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  // Days before each month, common and leap years
  localparam int MONTH_START [2][13] = '{
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
    '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}};

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        mday;
    logic [DOY_W-1:0]  yday;
    logic [2:0]        wday;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic              dst;
  } civil_t;

  typedef enum logic [2:0] {
    ROW_UTC, ROW_LOCAL, ROW_SET_OFFSET, ROW_SET_DST, ROW_SET_SPARE2, ROW_SET_SPARE3
  } row_kind_e;

  // value is the epoch seconds for requests, the write data for register rows
  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;
    logic        typed;
    civil_t      want;
  } plan_row_t;

  localparam civil_t NO_CIVIL = '0;
  localparam int PLAN_LEN = 29;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // epoch, one second before, 32-bit range ends
    '{ROW_UTC, 32'h0000_0000, 1'b1,
      '{11'd1970, 4'd0, 5'd1, 9'd0, 3'd4, 5'd0, 6'd0, 6'd0, 1'b0}},
    '{ROW_UTC, 32'hFFFF_FFFF, 1'b1,
      '{11'd1969, 4'd11, 5'd31, 9'd364, 3'd3, 5'd23, 6'd59, 6'd59, 1'b0}},
    '{ROW_UTC, 32'h7FFF_FFFF, 1'b1,
      '{11'd2038, 4'd0, 5'd19, 9'd18, 3'd2, 5'd3, 6'd14, 6'd7, 1'b0}},
    '{ROW_UTC, 32'h8000_0000, 1'b1,
      '{11'd1901, 4'd11, 5'd13, 9'd346, 3'd5, 5'd20, 6'd45, 6'd52, 1'b0}},
    // leap day and last second of a leap year
    '{ROW_UTC, 32'd951782400, 1'b1,
      '{11'd2000, 4'd1, 5'd29, 9'd59, 3'd2, 5'd0, 6'd0, 6'd0, 1'b0}},
    '{ROW_UTC, 32'd978307199, 1'b1,
      '{11'd2000, 4'd11, 5'd31, 9'd365, 3'd0, 5'd23, 6'd59, 6'd59, 1'b0}},
    // local mode with reset registers
    '{ROW_LOCAL, 32'h0000_0000, 1'b1,
      '{11'd1970, 4'd0, 5'd1, 9'd0, 3'd4, 5'd0, 6'd0, 6'd0, 1'b0}},
    // widest nominal offsets, daylight on
    '{ROW_SET_OFFSET, 32'd86399, 1'b0, NO_CIVIL},
    '{ROW_SET_DST, 32'd1, 1'b0, NO_CIVIL},
    '{ROW_LOCAL, 32'h0000_0000, 1'b0, NO_CIVIL},
    '{ROW_LOCAL, 32'hFFFF_FFFF, 1'b0, NO_CIVIL},
    '{ROW_UTC, 32'h7FFF_FFFF, 1'b0, NO_CIVIL},
    '{ROW_SET_OFFSET, 32'(-86399), 1'b0, NO_CIVIL},
    '{ROW_LOCAL, 32'h0000_0000, 1'b0, NO_CIVIL},
    '{ROW_LOCAL, 32'h8000_0000, 1'b0, NO_CIVIL},
    // offsets past one day, up to the register's extremes
    '{ROW_SET_OFFSET, 32'h0001_FFFF, 1'b0, NO_CIVIL},
    '{ROW_LOCAL, 32'h7FFF_FFFF, 1'b0, NO_CIVIL},
    '{ROW_LOCAL, 32'd951782399, 1'b0, NO_CIVIL},
    '{ROW_SET_OFFSET, 32'h0002_0000, 1'b0, NO_CIVIL},
    '{ROW_LOCAL, 32'h8000_0000, 1'b0, NO_CIVIL},
    '{ROW_LOCAL, 32'h0000_0000, 1'b0, NO_CIVIL},
    // spare indexes must leave both registers alone
    '{ROW_SET_SPARE2, 32'h0003_FFFF, 1'b0, NO_CIVIL},
    '{ROW_SET_SPARE3, 32'h0001_5555, 1'b0, NO_CIVIL},
    '{ROW_LOCAL, 32'd86399, 1'b0, NO_CIVIL},
    '{ROW_SET_DST, 32'd0, 1'b0, NO_CIVIL},
    '{ROW_LOCAL, 32'h5555_5555, 1'b0, NO_CIVIL},
    '{ROW_SET_OFFSET, 32'd0, 1'b0, NO_CIVIL},
    '{ROW_LOCAL, 32'hAAAA_AAAA, 1'b0, NO_CIVIL},
    '{ROW_UTC, 32'hFFFE_AE80, 1'b0, NO_CIVIL}};

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [SEC_W-1:0]  in_epoch_seconds;
  logic              in_local_mode;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [OFS_W-1:0]  cfg_data;
  logic              out_valid;
  logic [YEAR_W-1:0] out_full_year;
  logic [3:0]        out_month_index;
  logic [4:0]        out_day_of_month;
  logic [DOY_W-1:0]  out_day_of_year;
  logic [2:0]        out_weekday;
  logic [4:0]        out_hour_of_day;
  logic [5:0]        out_minute_of_hour;
  logic [5:0]        out_second_of_minute;
  logic              out_daylight_flag;

  // Register copies seen by the predictor
  logic signed [OFS_W-1:0] tz_offset;
  logic                    dst_on;

  civil_t civil_due [$];
  int     mismatch_count;
  int     cycle_count;
  int     burst_left;

  epoch_seconds_to_civil_time dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_epoch_seconds     (in_epoch_seconds),
    .in_local_mode        (in_local_mode),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_full_year        (out_full_year),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_day_of_year      (out_day_of_year),
    .out_weekday          (out_weekday),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute),
    .out_daylight_flag    (out_daylight_flag)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int is_leap(input int yr);
    return (yr % 4 == 0 && (yr % 100 != 0 || yr % 400 == 0)) ? 1 : 0;
  endfunction

  // Civil date and time for one request under the current registers
  function automatic civil_t civil_from_epoch(input logic [SEC_W-1:0] secs,
                                              input logic lmode);
    civil_t r;
    longint total, days, sod, wd;
    int     yr, mon, lp;
    total = longint'($signed(secs)) + (lmode ? longint'(tz_offset) : 64'sd0);
    days = total / DAY_SECONDS;
    if (total % DAY_SECONDS < 0) days--;
    sod = total - days * DAY_SECONDS;
    // 1970-01-01 was a Thursday
    wd = (4 + days) % 7;
    if (wd < 0) wd += 7;
    yr = 1970;
    while (days < 0) begin
      yr--;
      days += 365 + is_leap(yr);
    end
    while (days >= 365 + is_leap(yr)) begin
      days -= 365 + is_leap(yr);
      yr++;
    end
    r.yday = DOY_W'(days);
    lp = is_leap(yr);
    mon = 11;
    while (mon > 0 && days < MONTH_START[lp][mon]) mon--;
    days -= MONTH_START[lp][mon];
    r.year   = YEAR_W'(yr);
    r.month  = 4'(mon);
    r.mday   = 5'(days + 1);
    r.wday   = 3'(wd);
    r.hour   = 5'(sod / 3600);
    r.minute = 6'((sod % 3600) / 60);
    r.second = 6'(sod % 60);
    r.dst    = lmode ? dst_on : 1'b0;
    return r;
  endfunction

  // Signed day count from 1970-01-01 to January 1 of a year
  function automatic longint days_to_jan1(input int yr);
    longint d;
    d = 0;
    for (int k = 1970; k < yr; k++) d += 365 + is_leap(k);
    for (int k = yr; k < 1970; k++) d -= 365 + is_leap(k);
    return d;
  endfunction

  // Random request time, weighted toward day, month and year edges
  function automatic logic [SEC_W-1:0] pick_epoch(input logic lmode);
    int     yr, mon, lp, mlen, d;
    longint sod, v;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3:       return 32'h7FFF_FFFF - $urandom_range(0, 300000);
      4:       return 32'h8000_0000 + $urandom_range(0, 300000);
      5:       return 32'($urandom_range(0, 400000) - 200000);
      default: begin
        yr = $urandom_range(1901, 2038);
        mon = $urandom_range(0, 11);
        lp = is_leap(yr);
        mlen = MONTH_START[lp][mon + 1] - MONTH_START[lp][mon];
        case ($urandom_range(0, 2))
          0:       d = 0;
          1:       d = mlen - 1;
          default: d = $urandom_range(0, mlen - 1);
        endcase
        case ($urandom_range(0, 2))
          0:       sod = 0;
          1:       sod = DAY_SECONDS - 1;
          default: sod = $urandom_range(0, DAY_SECONDS - 1);
        endcase
        // aim the local time, not UTC, at the edge
        v = (days_to_jan1(yr) + MONTH_START[lp][mon] + d) * DAY_SECONDS + sod
            - (lmode ? longint'(tz_offset) : 64'sd0);
        if (v != longint'($signed(32'(v)))) return $urandom();
        return 32'(v);
      end
    endcase
  endfunction

  function automatic logic [OFS_W-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 18'h1FFFF;
      1:       return 18'h20000;
      2:       return OFS_W'(86399);
      3:       return OFS_W'(-86399);
      4:       return OFS_W'($urandom());
      default: return OFS_W'($urandom_range(0, 100800) - 50400);
    endcase
  endfunction

  // Idle cycles before the next request; bursts of back-to-back requests
  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic string civil_str(input civil_t c);
    return $sformatf("%0d-%0d-%0d yday %0d wday %0d %0d:%0d:%0d dst %0d",
                     c.year, c.month, c.mday, c.yday, c.wday,
                     c.hour, c.minute, c.second, c.dst);
  endfunction

  // Called and returns at a falling edge; start stays high for a following
  // back-to-back request
  task automatic send_request(input logic [SEC_W-1:0] secs, input logic lmode,
                              input logic typed, input civil_t want);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      start <= 1'b0;
      in_epoch_seconds <= $urandom();
      in_local_mode <= 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    start <= 1'b1;
    in_epoch_seconds <= secs;
    in_local_mode <= lmode;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    civil_due.push_back(typed ? want : civil_from_epoch(secs, lmode));
    @(negedge clk);
  endtask

  // Register write once every pending result is back
  task automatic write_register(input logic [1:0] idx, input logic [OFS_W-1:0] data);
    int gap;
    start <= 1'b0;
    while (civil_due.size() != 0) @(negedge clk);
    gap = $urandom_range(0, 19);
    repeat (gap) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_UTC_OFFSET: tz_offset = data;
      REG_DST_ACTIVE: dst_on = data[0];
      default: ;  // spare index, no effect
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    logic lm;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_epoch_seconds <= '0;
    in_local_mode <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_UTC_OFFSET;
    cfg_data <= '0;
    tz_offset = '0;
    dst_on = 1'b0;
    burst_left = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      case (PLAN[i].kind)
        ROW_UTC:        send_request(PLAN[i].value, 1'b0, PLAN[i].typed, PLAN[i].want);
        ROW_LOCAL:      send_request(PLAN[i].value, 1'b1, PLAN[i].typed, PLAN[i].want);
        ROW_SET_OFFSET: write_register(REG_UTC_OFFSET, PLAN[i].value[OFS_W-1:0]);
        ROW_SET_DST:    write_register(REG_DST_ACTIVE, PLAN[i].value[OFS_W-1:0]);
        ROW_SET_SPARE2: write_register(REG_SPARE_2, PLAN[i].value[OFS_W-1:0]);
        ROW_SET_SPARE3: write_register(REG_SPARE_3, PLAN[i].value[OFS_W-1:0]);
        default: ;
      endcase
    end

    // random phases, new registers each time; daylight data has noise above bit 0
    for (int phase = 0; phase < PHASES; phase++) begin
      write_register(REG_UTC_OFFSET, pick_offset());
      write_register(REG_DST_ACTIVE, OFS_W'($urandom()));
      if ($urandom_range(0, 3) == 0)
        write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, OFS_W'($urandom()));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        lm = ($urandom_range(0, 3) != 0);
        send_request(pick_epoch(lm), lm, 1'b0, NO_CIVIL);
      end
    end

    // drain, then let the pipeline run empty
    start <= 1'b0;
    while (civil_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Result checker
  always @(posedge clk) begin
    civil_t got;
    civil_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      got = '{out_full_year, out_month_index, out_day_of_month, out_day_of_year,
              out_weekday, out_hour_of_day, out_minute_of_hour, out_second_of_minute,
              out_daylight_flag};
      if (civil_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("tb: result with no request pending at %0t: %s", $realtime, civil_str(got));
      end else begin
        want = civil_due.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("tb: mismatch at %0t", $realtime);
            $display("  expected %s", civil_str(want));
            $display("  actual   %s", civil_str(got));
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    mismatch_count = 0;
  end

endmodule
